>>> design/assert_macros.svh
// Assertion macros shared by the fragment reassembly tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define FRT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FRT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/frt_pkg.sv
// Types and constants of the fragment reassembly tracker.
`default_nettype none
package frt_pkg;

    localparam logic [2:0] ST_QUEUED  = 3'd0;
    localparam logic [2:0] ST_DUP     = 3'd1;
    localparam logic [2:0] ST_PIECE   = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_NO_CTX  = 3'd4;
    localparam logic [2:0] ST_NO_SLOT = 3'd5;

    localparam logic [15:0] MORE_FLAG   = 16'h0001;
    localparam logic [15:0] OFFSET_MASK = 16'hFFF8;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_ITEM,
        EM_PIECE,
        EM_TIMEOUT
    } emit_t;

    typedef struct packed {
        logic [15:0] handle;
        logic [15:0] prefix;
        logic [15:0] length;
        logic [15:0] offset;
    } slot_t;

    typedef struct packed {
        logic       latch_in;
        logic       sel_ctx;
        logic       st_load;
        logic [2:0] st_code;
        logic       idx_clr;
        logic       idx_inc;
        logic       idx_dec;
        logic       shift_start;
        logic       rd_en;
        logic       rd_prev;
        logic       wr_shift;
        logic       wr_new;
        logic       acc_clr;
        logic       acc_add;
        logic       tick_start;
        logic       scan_inc;
        logic       free_ctx;
        emit_t      emit;
    } frt_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic hit;
        logic free_avail;
        logic full;
        logic idx_eq_n;
        logic idx_eq_pos;
        logic off_eq;
        logic off_le;
        logic final_seen;
        logic chk_ok;
        logic cnt_zero;
        logic idx_last;
        logic exp_cur;
        logic k_full;
        logic cur_last;
        logic out_free;
    } frt_sts_t;

endpackage
`default_nettype wire

>>> design/fragment_reassembly_tracker.sv
// A fragment is handled by a sequential walk over the slot memory: search, shift,
// insert and check, then one result per reassembled piece. A tick scans the contexts
// and emits timeout results for expired contexts. One item is in work at a time.
// Reset (aresetn low, synchronous) closes all contexts and sets timeout to 6000;
// slot memory is not cleared.
`default_nettype none
module fragment_reassembly_tracker #(
    parameter int NUM_CONTEXTS      = 8,
    parameter int FRAGS_PER_CONTEXT = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // packet_id, frag_word, data_len, hdr_prefix_len, next_proto, buffer_handle
    input  wire logic [103:0] s_tdata,
    // operation
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_packet_id, out_handle, out_offset, out_length, out_next_proto,
    // total_payload_len, zero pad
    output logic      [111:0] m_tdata,
    // status
    output logic      [2:0]   m_tuser,
    output logic              m_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [15:0]  cfg_data
);
    import frt_pkg::*;

    frt_cmd_t cmd;
    frt_sts_t sts;

    assign cfg_ready = 1'b1;

    frt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    frt_datapath #(
        .NUM_CONTEXTS     (NUM_CONTEXTS),
        .FRAGS_PER_CONTEXT(FRAGS_PER_CONTEXT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );
endmodule
`default_nettype wire

>>> design/frt_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module frt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

>>> design/frt_datapath.sv
// Context table, slot memory, counters and result register.
`default_nettype none
`include "assert_macros.svh"
module frt_datapath #(
    parameter int NUM_CONTEXTS      = 8,
    parameter int FRAGS_PER_CONTEXT = 16
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  frt_pkg::frt_cmd_t   cmd,
    output frt_pkg::frt_sts_t   sts,
    input  wire logic           s_tuser,
    input  wire logic [103:0]   s_tdata,
    input  wire logic           cfg_valid,
    input  wire logic [15:0]    cfg_data,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [111:0]        m_tdata,
    output logic [2:0]          m_tuser,
    output logic                m_tlast
);
    import frt_pkg::*;

    localparam int NC    = NUM_CONTEXTS;
    localparam int FPC   = FRAGS_PER_CONTEXT;
    localparam int CW    = (NC > 1) ? $clog2(NC) : 1;
    localparam int IW    = $clog2(FPC + 1);
    localparam int DEPTH = NC * FPC;
    localparam int AW    = $clog2(DEPTH);
    localparam int ACC_W = 16 + IW;

    logic [15:0] timeout_reg;

    logic        it_op_reg;
    logic [31:0] it_id_reg;
    logic [15:0] it_word_reg, it_len_reg, it_pre_reg, it_h_reg;
    logic [7:0]  it_np_reg;
    logic [15:0] it_off;

    logic [NC-1:0] ctx_valid_reg, ctx_final_reg, exp_reg;
    logic [IW-1:0] ctx_cnt_reg [NC];
    logic [31:0]   ctx_id_reg [NC];
    logic [7:0]    ctx_np_reg [NC];
    logic [15:0]   ctx_ticks_reg [NC];

    logic [CW-1:0]    cur_reg;
    logic [IW-1:0]    idx_reg, pos_reg, k_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [17:0]      tot_reg;
    logic [2:0]       st_reg;

    logic          hit, free_avail, later;
    logic [CW-1:0] hit_idx, free_idx;
    logic [IW-1:0] cur_cnt, rd_idx;
    logic [AW-1:0] raddr, waddr;
    logic          we;
    slot_t         wdata, rdata;

    assign it_off  = it_word_reg & OFFSET_MASK;
    assign cur_cnt = ctx_cnt_reg[cur_reg];

    always_comb begin
        hit        = 1'b0;
        free_avail = 1'b0;
        hit_idx    = '0;
        free_idx   = '0;
        later      = 1'b0;
        for (int c = NC - 1; c >= 0; c--) begin
            if (ctx_valid_reg[c] && ctx_id_reg[c] == it_id_reg) begin
                hit     = 1'b1;
                hit_idx = CW'(c);
            end
            if (!ctx_valid_reg[c]) begin
                free_avail = 1'b1;
                free_idx   = CW'(c);
            end
            if (exp_reg[c] && CW'(c) > cur_reg) begin
                later = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= 16'd6000;
        end else if (cfg_valid) begin
            timeout_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            it_op_reg   <= s_tuser;
            it_id_reg   <= s_tdata[31:0];
            it_word_reg <= s_tdata[47:32];
            it_len_reg  <= s_tdata[63:48];
            it_pre_reg  <= s_tdata[79:64];
            it_np_reg   <= s_tdata[87:80];
            it_h_reg    <= s_tdata[103:88];
        end
    end

    // context control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_valid_reg <= '0;
            ctx_final_reg <= '0;
            exp_reg       <= '0;
            for (int c = 0; c < NC; c++) begin
                ctx_cnt_reg[c] <= '0;
            end
        end else begin
            if (cmd.sel_ctx) begin
                if (!hit) begin
                    ctx_valid_reg[free_idx] <= 1'b1;
                    ctx_cnt_reg[free_idx]   <= '0;
                    ctx_final_reg[free_idx] <= (it_word_reg & MORE_FLAG) == 16'd0;
                end else if ((it_word_reg & MORE_FLAG) == 16'd0) begin
                    ctx_final_reg[hit_idx] <= 1'b1;
                end
            end
            if (cmd.wr_new) begin
                ctx_cnt_reg[cur_reg] <= cur_cnt + IW'(1);
            end
            if (cmd.free_ctx) begin
                ctx_valid_reg[cur_reg] <= 1'b0;
                ctx_final_reg[cur_reg] <= 1'b0;
                ctx_cnt_reg[cur_reg]   <= '0;
            end
            if (cmd.tick_start) begin
                for (int c = 0; c < NC; c++) begin
                    exp_reg[c] <= ctx_valid_reg[c] && ctx_ticks_reg[c] <= 16'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sel_ctx && !hit) begin
            ctx_id_reg[free_idx]    <= it_id_reg;
            ctx_np_reg[free_idx]    <= it_np_reg;
            ctx_ticks_reg[free_idx] <= timeout_reg;
        end
        if (cmd.tick_start) begin
            for (int c = 0; c < NC; c++) begin
                if (ctx_valid_reg[c] && ctx_ticks_reg[c] > 16'd1) begin
                    ctx_ticks_reg[c] <= ctx_ticks_reg[c] - 16'd1;
                end
            end
        end
    end

    // walk counters
    always_ff @(posedge aclk) begin
        if (cmd.sel_ctx) begin
            cur_reg <= hit ? hit_idx : free_idx;
        end else if (cmd.tick_start) begin
            cur_reg <= '0;
        end else if (cmd.scan_inc) begin
            cur_reg <= cur_reg + CW'(1);
        end
        if (cmd.idx_clr || cmd.tick_start) begin
            idx_reg <= '0;
        end else if (cmd.shift_start) begin
            idx_reg <= cur_cnt;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + IW'(1);
        end else if (cmd.idx_dec) begin
            idx_reg <= idx_reg - IW'(1);
        end
        if (cmd.shift_start) begin
            pos_reg <= idx_reg;
        end
        if (cmd.tick_start) begin
            k_reg <= '0;
        end else if (cmd.emit == EM_TIMEOUT) begin
            k_reg <= k_reg + IW'(1);
        end
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + ACC_W'(rdata.length);
            tot_reg <= 18'(rdata.prefix) + 18'(rdata.offset) + 18'(rdata.length);
        end
        if (cmd.st_load) begin
            st_reg <= cmd.st_code;
        end
    end

    assign rd_idx = cmd.rd_prev ? idx_reg - IW'(1) : idx_reg;
    assign raddr  = AW'(int'(cur_reg) * FPC + int'(rd_idx));
    assign waddr  = AW'(int'(cur_reg) * FPC + int'(idx_reg));
    assign we     = cmd.wr_shift || cmd.wr_new;

    always_comb begin
        if (cmd.wr_new) begin
            wdata = '{handle: it_h_reg, prefix: it_pre_reg, length: it_len_reg,
                      offset: it_off};
        end else begin
            wdata = rdata;
        end
    end

    frt_ram #(
        .WIDTH($bits(slot_t)),
        .DEPTH(DEPTH)
    ) u_slots (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (cmd.rd_en),
        .raddr(raddr),
        .rdata(rdata)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (cmd.emit != EM_NONE) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.emit)
            EM_ITEM: begin
                m_tuser  <= st_reg;
                m_tdata  <= {6'd0, 18'd0, (st_reg == ST_NO_CTX) ? 8'd0 : ctx_np_reg[cur_reg],
                             it_len_reg, it_off, it_h_reg, it_id_reg};
                m_tlast  <= 1'b1;
            end
            EM_PIECE: begin
                m_tuser  <= ST_PIECE;
                m_tdata  <= {6'd0, tot_reg, ctx_np_reg[cur_reg], rdata.length,
                             rdata.offset, rdata.handle, ctx_id_reg[cur_reg]};
                m_tlast  <= sts.idx_last;
            end
            EM_TIMEOUT: begin
                m_tuser  <= ST_TIMEOUT;
                m_tdata  <= {6'd0, 18'd0, ctx_np_reg[cur_reg],
                             sts.cnt_zero ? 16'd0 : rdata.length,
                             sts.cnt_zero ? 16'd0 : rdata.offset,
                             sts.cnt_zero ? 16'd0 : rdata.handle, ctx_id_reg[cur_reg]};
                m_tlast  <= !later || k_reg == IW'(FPC - 1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        sts.is_tick    = it_op_reg;
        sts.hit        = hit;
        sts.free_avail = free_avail;
        sts.full       = cur_cnt == IW'(FPC);
        sts.idx_eq_n   = idx_reg == cur_cnt;
        sts.idx_eq_pos = idx_reg == pos_reg;
        sts.off_eq     = it_off == rdata.offset;
        sts.off_le     = it_off <= rdata.offset;
        sts.final_seen = ctx_final_reg[cur_reg];
        sts.chk_ok     = acc_reg == ACC_W'(rdata.offset);
        sts.cnt_zero   = cur_cnt == '0;
        sts.idx_last   = (idx_reg + IW'(1)) == cur_cnt;
        sts.exp_cur    = exp_reg[cur_reg];
        sts.k_full     = k_reg == IW'(FPC);
        sts.cur_last   = cur_reg == CW'(NC - 1);
        sts.out_free   = !m_tvalid || m_tready;
    end

    `FRT_ASSERT_NXT(a_piece_frees, aclk, aresetn, cmd.emit == EM_PIECE && cmd.free_ctx, !ctx_valid_reg[cur_reg], "context still open after reassembly")
    `FRT_ASSERT_IMP(a_insert_room, aclk, aresetn, cmd.wr_new, cur_cnt != IW'(FPC), "insert into full context")
endmodule
`default_nettype wire

>>> design/frt_ctrl.sv
// Sequencer of the fragment reassembly tracker.
`default_nettype none
`include "assert_macros.svh"
module frt_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  frt_pkg::frt_sts_t sts,
    output frt_pkg::frt_cmd_t cmd
);
    import frt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_INS0, S_SRD, S_SCMP, S_SHIFT, S_SHWR, S_CHK0,
        S_CRD, S_CCMP, S_EMIT1, S_PRD, S_PEM, S_TSCAN, S_TEM
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = state_reg == S_IDLE;

    always_comb begin
        cmd        = '0;
        cmd.emit   = EM_NONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DISP;
                end
            end
            S_DISP: begin
                if (sts.is_tick) begin
                    cmd.tick_start = 1'b1;
                    state_next     = S_TSCAN;
                end else if (!sts.hit && !sts.free_avail) begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_NO_CTX;
                    state_next  = S_EMIT1;
                end else begin
                    cmd.sel_ctx = 1'b1;
                    state_next  = S_INS0;
                end
            end
            S_INS0: begin
                if (sts.full) begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_NO_SLOT;
                    state_next  = S_CHK0;
                end else begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_SRD;
                end
            end
            S_SRD: begin
                if (sts.idx_eq_n) begin
                    cmd.shift_start = 1'b1;
                    state_next      = S_SHIFT;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_SCMP;
                end
            end
            S_SCMP: begin
                if (sts.off_eq) begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_DUP;
                    state_next  = S_CHK0;
                end else if (sts.off_le) begin
                    cmd.shift_start = 1'b1;
                    state_next      = S_SHIFT;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SRD;
                end
            end
            S_SHIFT: begin
                if (sts.idx_eq_pos) begin
                    cmd.wr_new  = 1'b1;
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_QUEUED;
                    state_next  = S_CHK0;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_prev = 1'b1;
                    state_next  = S_SHWR;
                end
            end
            S_SHWR: begin
                cmd.wr_shift = 1'b1;
                cmd.idx_dec  = 1'b1;
                state_next   = S_SHIFT;
            end
            S_CHK0: begin
                if (!sts.final_seen) begin
                    state_next = S_EMIT1;
                end else begin
                    cmd.idx_clr = 1'b1;
                    cmd.acc_clr = 1'b1;
                    state_next  = S_CRD;
                end
            end
            S_CRD: begin
                if (sts.idx_eq_n) begin
                    if (sts.cnt_zero) begin
                        state_next = S_EMIT1;
                    end else begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_PRD;
                    end
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_CCMP;
                end
            end
            S_CCMP: begin
                if (sts.chk_ok) begin
                    cmd.acc_add = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next  = S_CRD;
                end else begin
                    state_next = S_EMIT1;
                end
            end
            S_EMIT1: begin
                if (sts.out_free) begin
                    cmd.emit   = EM_ITEM;
                    state_next = S_IDLE;
                end
            end
            S_PRD: begin
                cmd.rd_en  = 1'b1;
                state_next = S_PEM;
            end
            S_PEM: begin
                if (sts.out_free) begin
                    cmd.emit = EM_PIECE;
                    if (sts.idx_last) begin
                        cmd.free_ctx = 1'b1;
                        state_next   = S_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_PRD;
                    end
                end
            end
            S_TSCAN: begin
                if (sts.exp_cur && !sts.k_full) begin
                    cmd.rd_en  = !sts.cnt_zero;
                    state_next = S_TEM;
                end else if (sts.cur_last) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.scan_inc = 1'b1;
                end
            end
            S_TEM: begin
                if (sts.out_free) begin
                    cmd.emit     = EM_TIMEOUT;
                    cmd.free_ctx = 1'b1;
                    if (sts.cur_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.scan_inc = 1'b1;
                        state_next   = S_TSCAN;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `FRT_ASSERT_IMP(a_emit_free, aclk, aresetn, cmd.emit != EM_NONE, sts.out_free, "result loaded while output busy")
endmodule
`default_nettype wire
